FILE: hdl/lfpr_pkg.sv
package lfpr_pkg;

    localparam int LFPR_MAX_FRAME = 4096;
    localparam int HEADER_BYTES   = 6;
    localparam int FRAME_OVERHEAD = 8;
    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 12;
    localparam int SUM_W          = 16;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic              frame_end;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] frame_type;
        logic [LEN_W-1:0]  payload_length;
        t_status           status;
    } t_result;

endpackage

FILE: hdl/lfpr_in_reg.sv
module lfpr_in_reg import lfpr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_ready,
    input  logic              i_take,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

FILE: hdl/lfpr_core.sv
module lfpr_core import lfpr_pkg::*; #(
    parameter int MAX_FRAME = LFPR_MAX_FRAME
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_fire,
    output logic              o_has_res,
    output t_result           o_res
);

    localparam int PW = $clog2(MAX_FRAME);
    localparam logic [31:0]   LIMIT        = 32'(MAX_FRAME - FRAME_OVERHEAD);
    localparam logic [PW-1:0] HDR          = PW'(HEADER_BYTES);
    localparam logic [PW-1:0] POS_TYPE     = PW'(1);
    localparam logic [PW-1:0] POS_LEN0     = PW'(2);
    localparam logic [PW-1:0] POS_LAST_HDR = PW'(HEADER_BYTES - 1);

    logic [PW-1:0]     r_pos,  n_pos;
    logic [23:0]       r_acc,  n_acc;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [SUM_W-1:0]  r_sum,  n_sum;
    logic [BYTE_W-1:0] r_chk,  n_chk;
    logic [PW-1:0]     r_len,  n_len;
    logic [PW-1:0]     r_end,  n_end;

    logic [31:0]       acc_word;
    logic [31:0]       len_ext;
    logic [SUM_W-1:0]  got_sum;

    always_comb begin
        acc_word  = {r_acc, i_byte};
        len_ext   = 32'(r_len);
        got_sum   = {r_chk, i_byte};
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_type    = r_type;
        n_sum     = r_sum;
        n_chk     = r_chk;
        n_len     = r_len;
        n_end     = r_end;
        o_has_res = 1'b0;
        o_res.frame_end      = 1'b0;
        o_res.payload_byte   = '0;
        o_res.frame_type     = r_type;
        o_res.payload_length = '0;
        o_res.status         = ST_GOOD;
        priority if (r_pos < HDR) begin
            n_sum = r_sum + SUM_W'(i_byte);
            n_pos = r_pos + PW'(1);
            if (r_pos == POS_TYPE) begin
                n_type = i_byte;
            end else if (r_pos >= POS_LEN0) begin
                n_acc = acc_word[23:0];
            end
            if (r_pos == POS_LAST_HDR) begin
                if (acc_word > LIMIT) begin
                    o_has_res       = 1'b1;
                    o_res.frame_end = 1'b1;
                    o_res.status    = ST_TOO_LONG;
                    n_pos  = '0;
                    n_acc  = '0;
                    n_type = '0;
                    n_sum  = '0;
                    n_chk  = '0;
                end else begin
                    n_len = acc_word[PW-1:0];
                    n_end = acc_word[PW-1:0] + HDR;
                end
            end
        end else if (r_pos < r_end) begin
            n_sum = r_sum + SUM_W'(i_byte);
            n_pos = r_pos + PW'(1);
            o_has_res            = 1'b1;
            o_res.payload_byte   = i_byte;
            o_res.payload_length = len_ext[LEN_W-1:0];
        end else if (r_pos == r_end) begin
            n_chk = i_byte;
            n_pos = r_pos + PW'(1);
        end else begin
            o_has_res            = 1'b1;
            o_res.frame_end      = 1'b1;
            o_res.payload_length = len_ext[LEN_W-1:0];
            o_res.status         = (got_sum == r_sum) ? ST_GOOD : ST_MISMATCH;
            n_pos  = '0;
            n_acc  = '0;
            n_type = '0;
            n_sum  = '0;
            n_chk  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_acc  <= '0;
            r_type <= '0;
            r_sum  <= '0;
            r_chk  <= '0;
        end else if (i_fire) begin
            r_pos  <= n_pos;
            r_acc  <= n_acc;
            r_type <= n_type;
            r_sum  <= n_sum;
            r_chk  <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_len <= n_len;
            r_end <= n_end;
        end
    end

endmodule

FILE: hdl/lfpr_out_reg.sv
module lfpr_out_reg import lfpr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: hdl/length_framed_packet_receiver.sv
// An accepted byte is held in the input register and its result in the output register.
// Throughput: 1 byte per cycle unless a result waits on the output; the frame counter
// and running sum step once per byte. Legal header and checksum-high bytes never wait.
// Reset (i_rst_n low, synchronous) empties both registers and returns to frame start.
module length_framed_packet_receiver import lfpr_pkg::*; #(
    parameter int MAX_FRAME = LFPR_MAX_FRAME
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic              o_frame_end,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic [BYTE_W-1:0] o_frame_type,
    output logic [LEN_W-1:0]  o_payload_length,
    output logic [1:0]        o_status
);

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              take;
    logic              has_res;
    logic              out_space;
    t_result           core_res;
    t_result           out_res;

    assign take = in_valid && (!has_res || out_space);

    lfpr_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx_valid),
        .i_byte  (i_rx_byte),
        .o_ready (o_rx_ready),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    lfpr_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (in_byte),
        .i_fire    (take),
        .o_has_res (has_res),
        .o_res     (core_res)
    );

    lfpr_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && has_res),
        .i_res   (core_res),
        .o_space (out_space),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_res   (out_res)
    );

    assign o_frame_end      = out_res.frame_end;
    assign o_payload_byte   = out_res.payload_byte;
    assign o_frame_type     = out_res.frame_type;
    assign o_payload_length = out_res.payload_length;
    assign o_status         = out_res.status;

endmodule

FILE: hdl/lfpr_checker.sv
module lfpr_checker import lfpr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_res_valid,
    input logic              i_res_ready,
    input logic              o_frame_end,
    input logic [BYTE_W-1:0] o_payload_byte,
    input logic [LEN_W-1:0]  o_payload_length,
    input logic [1:0]        o_status
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_payload_byte)
            && $stable(o_status) && $stable(o_frame_end))
        else $error("stalled result changed");

    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_frame_end |-> o_status == ST_GOOD)
        else $error("payload item with nonzero status");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_frame_end |-> o_payload_byte == '0
            && (o_status == ST_GOOD || o_status == ST_MISMATCH
                || o_status == ST_TOO_LONG))
        else $error("bad end-of-frame item");

    a_too_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status == ST_TOO_LONG |-> o_frame_end && o_payload_length == '0)
        else $error("length error item malformed");

endmodule

bind length_framed_packet_receiver lfpr_checker u_lfpr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_res_valid      (o_res_valid),
    .i_res_ready      (i_res_ready),
    .o_frame_end      (o_frame_end),
    .o_payload_byte   (o_payload_byte),
    .o_payload_length (o_payload_length),
    .o_status         (o_status)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lfpr_pkg::*;

    localparam int LEN_LIMIT  = LFPR_MAX_FRAME - FRAME_OVERHEAD;
    localparam int IDLE_LIMIT = 400;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_rx_valid = 1'b0;
    logic [BYTE_W-1:0] i_rx_byte = '0;
    logic              i_res_ready = 1'b0;
    logic              o_rx_ready;
    logic              o_res_valid;
    logic              o_frame_end;
    logic [BYTE_W-1:0] o_payload_byte;
    logic [BYTE_W-1:0] o_frame_type;
    logic [LEN_W-1:0]  o_payload_length;
    logic [1:0]        o_status;

    logic [BYTE_W-1:0] rx_byte_q[$];
    t_result           frame_out_q[$];

    int unsigned       frm_pos = 0;
    logic [31:0]       frm_len = '0;
    logic [7:0]        frm_type = '0;
    logic [15:0]       frm_sum = '0;
    logic [7:0]        frm_ck_hi = '0;

    bit                rx_taken = 1'b0;
    bit                bursts_on = 1'b1;
    int                rx_gap_left = 0;
    int                res_stall_left = 0;
    int                idle_cycles = 0;
    int                fail_count = 0;
    int                items_queued = 0;
    int                items_taken = 0;
    int                results_seen = 0;
    int                frames_good = 0;
    int                frames_bad = 0;
    int                frames_long = 0;
    bit                moved;

    length_framed_packet_receiver dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_frame_end      (o_frame_end),
        .o_payload_byte   (o_payload_byte),
        .o_frame_type     (o_frame_type),
        .o_payload_length (o_payload_length),
        .o_status         (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void clear_frame();
        frm_pos   = 0;
        frm_len   = '0;
        frm_type  = '0;
        frm_sum   = '0;
        frm_ck_hi = '0;
    endfunction

    function automatic void advance_frame(input logic [7:0] b);
        t_result     r;
        logic [15:0] got;
        r = '0;
        if (frm_pos < HEADER_BYTES) begin
            frm_sum = frm_sum + b;
            if (frm_pos == 1) begin
                frm_type = b;
            end else if (frm_pos >= 2) begin
                frm_len = {frm_len[23:0], b};
            end
            frm_pos++;
            if (frm_pos == HEADER_BYTES && frm_len > LEN_LIMIT) begin
                r.frame_end  = 1'b1;
                r.frame_type = frm_type;
                r.status     = ST_TOO_LONG;
                frame_out_q.push_back(r);
                frames_long++;
                clear_frame();
            end
        end else if (frm_pos - HEADER_BYTES < frm_len) begin
            frm_sum = frm_sum + b;
            frm_pos++;
            r.payload_byte   = b;
            r.frame_type     = frm_type;
            r.payload_length = frm_len[LEN_W-1:0];
            r.status         = ST_GOOD;
            frame_out_q.push_back(r);
        end else if (frm_pos - HEADER_BYTES == frm_len) begin
            frm_ck_hi = b;
            frm_pos++;
        end else begin
            got = {frm_ck_hi, b};
            r.frame_end      = 1'b1;
            r.frame_type     = frm_type;
            r.payload_length = frm_len[LEN_W-1:0];
            r.status         = (got == frm_sum) ? ST_GOOD : ST_MISMATCH;
            if (got == frm_sum) begin
                frames_good++;
            end else begin
                frames_bad++;
            end
            frame_out_q.push_back(r);
            clear_frame();
        end
    endfunction

    function automatic void check_field(input string name, input int exp, input int act);
        if (exp != act) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp, act);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_rx_valid && o_rx_ready) begin
                rx_taken = 1'b1;
                items_taken++;
                advance_frame(i_rx_byte);
                moved = 1'b1;
            end
            if (o_res_valid && i_res_ready) begin
                moved = 1'b1;
                results_seen++;
                if (frame_out_q.size() == 0) begin
                    $error("result with no item pending: frame_end %0d payload_byte %0d",
                           o_frame_end, o_payload_byte);
                    fail_count++;
                end else begin
                    t_result r;
                    r = frame_out_q.pop_front();
                    check_field("frame_end", r.frame_end, o_frame_end);
                    check_field("payload_byte", r.payload_byte, o_payload_byte);
                    check_field("frame_type", r.frame_type, o_frame_type);
                    check_field("payload_length", r.payload_length, o_payload_length);
                    check_field("status", r.status, o_status);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else if (!i_rx_valid || rx_taken) begin
            rx_taken = 1'b0;
            if (rx_gap_left > 0) begin
                rx_gap_left--;
                i_rx_valid <= 1'b0;
            end else if (rx_byte_q.size() != 0 && bursts_on && $urandom_range(0, 9) == 0) begin
                rx_gap_left = $urandom_range(1, 12) - 1;
                i_rx_valid <= 1'b0;
            end else if (rx_byte_q.size() != 0) begin
                i_rx_valid <= 1'b1;
                i_rx_byte  <= rx_byte_q.pop_front();
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else if (res_stall_left > 0) begin
            res_stall_left--;
            i_res_ready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 9) == 0) begin
            res_stall_left = $urandom_range(1, 12) - 1;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        rx_byte_q.push_back(b);
        items_queued++;
    endtask

    // fill < 0 gives random payload bytes
    task automatic queue_frame(input logic [7:0] start, input logic [7:0] ftype,
                               input logic [31:0] len, input bit corrupt, input int fill);
        logic [15:0] sum;
        logic [7:0]  b;
        sum = start + ftype;
        queue_byte(start);
        queue_byte(ftype);
        for (int i = 3; i >= 0; i--) begin
            b = len[i*8 +: 8];
            sum = sum + b;
            queue_byte(b);
        end
        if (len <= LEN_LIMIT) begin
            for (int unsigned i = 0; i < len; i++) begin
                b = (fill < 0) ? 8'($urandom) : 8'(fill);
                sum = sum + b;
                queue_byte(b);
            end
            if (corrupt) begin
                sum = sum + 16'($urandom_range(1, 65535));
            end
            queue_byte(sum[15:8]);
            queue_byte(sum[7:0]);
        end
    endtask

    task automatic queue_random_until(input int target);
        int          pick;
        logic [31:0] len;
        while (items_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                repeat ($urandom_range(1, 5)) queue_byte(8'($urandom));
            end else if (pick < 10) begin
                len = $urandom;
                if (len <= LEN_LIMIT) begin
                    len = len + LEN_LIMIT + 1;
                end
                queue_frame(8'($urandom_range(1, 255)), 8'($urandom), len, 1'b0, -1);
            end else begin
                len = ($urandom_range(0, 49) == 0) ? $urandom_range(25, 600)
                                                   : $urandom_range(0, 24);
                queue_frame(8'($urandom_range(1, 255)), 8'($urandom), len,
                            pick < 22, -1);
            end
        end
    endtask

    task automatic wait_drained();
        while (rx_byte_q.size() != 0 || i_rx_valid || frame_out_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_frame(8'h00, 8'h00, 32'd0, 1'b0, 0);
        queue_frame(8'hFF, 8'hFF, 32'd1, 1'b1, 8'hFF);
        queue_frame(8'hA5, 8'h5A, LEN_LIMIT + 1, 1'b0, -1);
        wait_drained();

        queue_frame(8'h3C, 8'hC3, 32'hFFFF_FFFF, 1'b0, -1);
        queue_random_until(items_queued + 800);
        wait_drained();

        queue_frame(8'h81, 8'h7E, 32'd300, 1'b0, -1);
        queue_random_until(items_queued + 450);
        wait_drained();

        bursts_on = 1'b0;
        queue_random_until(items_queued + 200);
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("%0d bytes in, %0d results out; frames: %0d good, %0d bad checksum, %0d too long",
                 items_taken, results_seen, frames_good, frames_bad, frames_long);
        $display("covered empty, long and oversized lengths, random noise and drain pauses");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
